// ===== sv/skeleton_node_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// skeleton_node_classifier_macros.svh
// Assertion macros for the skeleton node classifier; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef SKELETON_NODE_CLASSIFIER_MACROS_SVH
`define SKELETON_NODE_CLASSIFIER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off while rst_n is low
`define SNC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snc assertion failed");
// next-cycle implication
`define SNC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snc assertion failed");
`else
`define SNC_ASSERT_IMP(label, ante, cons)
`define SNC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== sv/snc_pkg.sv =====
// ---------------------------------------------------------------------------
// snc_pkg
// Types and constants for the skeleton node classifier.
// ---------------------------------------------------------------------------
`default_nettype none

package snc_pkg;

  localparam int SNC_MAX_WIDTH  = 1024;
  localparam int SNC_MAX_HEIGHT = 1024;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_HEIGHT = 11'd480;
  localparam int                    CFG_MIN_SIZE     = 3;

  // node types
  localparam logic NODE_ENDPOINT = 1'b0;
  localparam logic NODE_JUNCTION = 1'b1;

  // input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic kind;
    logic pixel;
  } snc_in_t;

  typedef struct packed {
    logic [9:0] node_row;
    logic [9:0] node_col;
    logic       node_type;
    logic [2:0] branch_count;
  } snc_out_t;

  typedef struct packed {
    logic       hit;
    logic       node_type;
    logic [2:0] branch_count;
  } snc_cls_t;

endpackage

`default_nettype wire

// ===== sv/skeleton_node_classifier.sv =====
// ---------------------------------------------------------------------------
// skeleton_node_classifier
// 3x3 endpoint / junction detection on a raster-order binary skeleton stream.
// ---------------------------------------------------------------------------
//
//  channel | ports                               | payload
//  --------+-------------------------------------+-------------------------
//  in      | in_valid, in_stall, in_data         | snc_in_t  (kind, pixel)
//  out     | out_valid, out_stall, out_data      | snc_out_t (row, col, type, count)
//  cfg     | cfg_we, cfg_index, cfg_wdata        | image_width, image_height
//
//  One request accepted per cycle while in_stall is low; a node whose window is
//  completed leaves through the bank read register, then the output register.
//  After reset the line buffers are cleared, one column of both banks per cycle
//  over all MAX_WIDTH columns; in_stall stays high during that pass.
//  Outside that pass, in_stall rises only when the output register is full and
//  out_stall holds it and the pixel stage behind it is also full.
//  Configuration writes take effect at the next request; sizes are clamped to
//  [3, MAX_WIDTH] and [3, MAX_HEIGHT].
// ---------------------------------------------------------------------------
`default_nettype none
`include "skeleton_node_classifier_macros.svh"

module skeleton_node_classifier
  import snc_pkg::*;
#(
  parameter int MAX_WIDTH  = SNC_MAX_WIDTH,
  parameter int MAX_HEIGHT = SNC_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire snc_in_t               in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output snc_out_t                   out_data,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // column index, effective size and row counter widths
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  // -------------------------------------------------------------------------
  // helpers
  // -------------------------------------------------------------------------
  function automatic logic [31:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                             input logic [31:0] hi);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'(CFG_MIN_SIZE)) begin
      return 32'(CFG_MIN_SIZE);
    end else if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  // ring order: NW, N, NE, E, SE, S, SW, W ; window bit = 3*column + row
  function automatic snc_cls_t classify(input logic [8:0] w);
    logic [7:0] ring;
    logic [7:0] nxt;
    logic [3:0] sum;
    logic       apart;
    snc_cls_t   res;
    ring  = {w[1], w[2], w[5], w[8], w[7], w[6], w[3], w[0]};
    nxt   = {ring[0], ring[7:1]};
    apart = ~|(ring & nxt);
    sum   = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + 4'(ring[k]);
    end
    res = '0;
    if (w[4]) begin
      if (sum == 4'd1) begin
        res.hit          = 1'b1;
        res.node_type    = NODE_ENDPOINT;
        res.branch_count = 3'd1;
      end else if (apart && sum == 4'd3) begin
        res.hit          = 1'b1;
        res.node_type    = NODE_JUNCTION;
        res.branch_count = 3'd3;
      end else if (apart && sum >= 4'd4) begin
        res.hit          = 1'b1;
        res.node_type    = NODE_JUNCTION;
        res.branch_count = 3'(sum - 4'd1);
      end
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // configuration: clamped sizes kept in registers
  // -------------------------------------------------------------------------
  logic [WW-1:0] w_eff_r;
  logic [HW-1:0] h_eff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(clamp_size(CFG_RESET_WIDTH, 32'(MAX_WIDTH)));
      h_eff_r <= HW'(clamp_size(CFG_RESET_HEIGHT, 32'(MAX_HEIGHT)));
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  w_eff_r <= WW'(clamp_size(cfg_wdata, 32'(MAX_WIDTH)));
        CFG_IDX_HEIGHT: h_eff_r <= HW'(clamp_size(cfg_wdata, 32'(MAX_HEIGHT)));
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // line buffer clearing pass after reset
  // -------------------------------------------------------------------------
  logic          clr_active_r;
  logic [CW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_cnt_r == CW'(MAX_WIDTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // handshake
  // -------------------------------------------------------------------------
  logic out_valid_r;
  logic s1_valid_r;
  logic out_free;
  logic s1_free;
  logic in_accept;
  logic s1_adv;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign s1_free   = ~s1_valid_r | out_free;
  assign s1_adv    = s1_valid_r & out_free;
  assign in_stall  = clr_active_r | ~s1_free;
  assign in_accept = in_valid & ~in_stall;

  // -------------------------------------------------------------------------
  // stage 0: stream position, pixel value, judged position
  // -------------------------------------------------------------------------
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;

  logic [RW:0]   row_a;    // position after a column overrun
  logic [CW-1:0] col_a;
  logic [RW-1:0] r_cur;    // position of this request
  logic [CW-1:0] c_cur;
  logic          c_zero;
  logic          v_cur;
  logic          top_en;
  logic          mid_en;
  logic          judge_ok;
  logic [RW-1:0] crow;
  logic [9:0]    crow_out;
  logic [9:0]    ccol_out;

  always_comb begin
    // bring the stored position back into range for the current sizes
    if (32'(in_col_r) >= 32'(w_eff_r)) begin
      col_a = '0;
      row_a = (RW+1)'(in_row_r) + 1'b1;
    end else begin
      col_a = in_col_r;
      row_a = (RW+1)'(in_row_r);
    end
    if (32'(row_a) > 32'(h_eff_r) + 32'd1 ||
        (32'(row_a) == 32'(h_eff_r) + 32'd1 && col_a != '0)) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      r_cur = RW'(row_a);
      c_cur = col_a;
    end

    c_zero = (c_cur == '0);
    // flush items and anything below the frame count as background
    v_cur  = (in_data.kind == KIND_PIXEL) ? in_data.pixel : 1'b0;
    if (32'(r_cur) >= 32'(h_eff_r)) begin
      v_cur = 1'b0;
    end
    top_en = (32'(r_cur) >= 32'd2);
    mid_en = (r_cur != '0);

    // column 0 closes the previous row; other columns judge one step behind
    if (c_zero) begin
      crow     = r_cur - RW'(2);
      ccol_out = 10'(32'(w_eff_r) - 32'd1);
      judge_ok = top_en;
    end else begin
      crow     = r_cur - RW'(1);
      ccol_out = 10'(32'(c_cur) - 32'd1);
      judge_ok = mid_en;
    end
    crow_out = 10'(crow);
    if (32'(crow) >= 32'(h_eff_r)) begin
      judge_ok = 1'b0;
    end

    // next position
    if (32'(r_cur) == 32'(h_eff_r) + 32'd1) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (32'(c_cur) + 32'd1 >= 32'(w_eff_r)) begin
      in_row_nxt = r_cur + 1'b1;
      in_col_nxt = '0;
    end else begin
      in_row_nxt = r_cur;
      in_col_nxt = c_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
    end else if (in_accept) begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // line buffers: one bank per row parity, both read at the request column
  // -------------------------------------------------------------------------
  logic bank0_mem [MAX_WIDTH];
  logic bank1_mem [MAX_WIDTH];
  logic bank0_rd_r;
  logic bank1_rd_r;

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      bank0_mem[clr_cnt_r] <= 1'b0;
    end else if (in_accept && !r_cur[0]) begin
      bank0_mem[c_cur] <= v_cur;
    end
    if (in_accept) begin
      bank0_rd_r <= bank0_mem[c_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      bank1_mem[clr_cnt_r] <= 1'b0;
    end else if (in_accept && r_cur[0]) begin
      bank1_mem[c_cur] <= v_cur;
    end
    if (in_accept) begin
      bank1_rd_r <= bank1_mem[c_cur];
    end
  end

  // -------------------------------------------------------------------------
  // stage 1 registers (payload holds while stage is stalled)
  // -------------------------------------------------------------------------
  logic       s1_czero_r;
  logic       s1_judge_r;
  logic       s1_par_r;
  logic       s1_top_en_r;
  logic       s1_mid_en_r;
  logic       s1_v_r;
  logic [9:0] s1_row_r;
  logic [9:0] s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_czero_r  <= c_zero;
      s1_judge_r  <= judge_ok;
      s1_par_r    <= r_cur[0];
      s1_top_en_r <= top_en;
      s1_mid_en_r <= mid_en;
      s1_v_r      <= v_cur;
      s1_row_r    <= crow_out;
      s1_col_r    <= ccol_out;
    end
  end

  // -------------------------------------------------------------------------
  // stage 1 logic: window shift and classification
  // -------------------------------------------------------------------------
  logic [8:0] win_r, win_nxt;
  logic [2:0] new_col;       // bit 0 top, bit 2 current
  logic [8:0] judged;
  logic       top_bit;
  logic       mid_bit;
  snc_cls_t   cls;

  always_comb begin
    top_bit = s1_top_en_r & (s1_par_r ? bank1_rd_r : bank0_rd_r);
    mid_bit = s1_mid_en_r & (s1_par_r ? bank0_rd_r : bank1_rd_r);
    new_col = {s1_v_r, mid_bit, top_bit};
    if (s1_czero_r) begin
      // row wrap: judge the last column with an empty right column
      judged  = {3'b000, win_r[8:3]};
      win_nxt = {new_col, 6'b000000};
    end else begin
      win_nxt = {new_col, win_r[8:3]};
      judged  = win_nxt;
    end
    cls = classify(judged);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  snc_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r & s1_judge_r & cls.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r.node_row     <= s1_row_r;
      out_data_r.node_col     <= s1_col_r;
      out_data_r.node_type    <= cls.node_type;
      out_data_r.branch_count <= cls.branch_count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `SNC_ASSERT_IMP(a_no_accept_in_clear, clr_active_r, in_stall)
  `SNC_ASSERT_NXT(a_accept_fills_s1, in_accept, s1_valid_r)
  `SNC_ASSERT_NXT(a_s1_holds, s1_valid_r && !out_free, s1_valid_r)
  `SNC_ASSERT_IMP(a_endpoint_count, out_valid_r && out_data_r.node_type == NODE_ENDPOINT,
                  out_data_r.branch_count == 3'd1)
  `SNC_ASSERT_IMP(a_junction_count, out_valid_r && out_data_r.node_type == NODE_JUNCTION,
                  out_data_r.branch_count >= 3'd3)

endmodule

`default_nettype wire

// ===== sim/snc_node_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// snc_node_checker
// Watches the request, result and register ports of the skeleton node
// classifier, predicts each node from its own line buffers and 3x3 window,
// and compares every result field against the oldest predicted node.
// ---------------------------------------------------------------------------
module snc_node_checker
  import snc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  snc_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  snc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    outstanding
);

  logic [CFG_DATA_W-1:0] width_reg  = CFG_RESET_WIDTH;
  logic [CFG_DATA_W-1:0] height_reg = CFG_RESET_HEIGHT;
  bit          line_bank [2][SNC_MAX_WIDTH];
  bit [8:0]    win;
  int unsigned pos_row, pos_col;
  snc_out_t    expected_nodes [$];
  int          fails   = 0;
  int          waiting = 0;

  assign errors      = fails;
  assign outstanding = waiting;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < CFG_MIN_SIZE) return CFG_MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // patch bit 3*column+row, column 0 is the oldest, row 0 the top
  function automatic bit grade_center(input bit [8:0] p, output logic kind,
                                      output logic [2:0] cnt);
    bit [7:0] ring;
    int       sum;
    bit       apart;
    kind  = NODE_ENDPOINT;
    cnt   = 3'd0;
    ring  = {p[1], p[2], p[5], p[8], p[7], p[6], p[3], p[0]};
    sum   = $countones(ring);
    apart = (ring & {ring[0], ring[7:1]}) == 8'd0;
    if (!p[4]) return 1'b0;
    if (sum == 1) begin
      cnt = 3'd1;
      return 1'b1;
    end
    if (apart && sum >= 3) begin
      kind = NODE_JUNCTION;
      cnt  = (sum == 3) ? 3'd3 : 3'(sum - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_request(snc_in_t req);
    int unsigned w, h, jr, jc;
    bit          v, ok, bank;
    bit [2:0]    column;
    bit [8:0]    patch;
    snc_out_t    node;
    logic        kind;
    logic [2:0]  cnt;
    w = clamp_size(width_reg, SNC_MAX_WIDTH);
    h = clamp_size(height_reg, SNC_MAX_HEIGHT);
    // a size change can leave the position out of range
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row > h + 1 || (pos_row == h + 1 && pos_col > 0)) begin
      pos_row = 0;
      pos_col = 0;
    end
    v = (req.kind == KIND_PIXEL) ? req.pixel : 1'b0;
    if (pos_row >= h) v = 1'b0;
    bank = pos_row[0];
    column[0] = (pos_row >= 2) ? line_bank[bank][pos_col] : 1'b0;
    column[1] = (pos_row >= 1) ? line_bank[!bank][pos_col] : 1'b0;
    column[2] = v;
    line_bank[bank][pos_col] = v;
    if (pos_col == 0) begin
      // row start judges the last pixel two rows up, right column empty
      patch = win >> 3;
      ok    = pos_row >= 2;
      jr    = pos_row - 2;
      jc    = w - 1;
      win   = {column, 6'd0};
    end else begin
      win   = {column, win[8:3]};
      patch = win;
      ok    = pos_row >= 1;
      jr    = pos_row - 1;
      jc    = pos_col - 1;
    end
    if (ok && jr < h && grade_center(patch, kind, cnt)) begin
      node.node_row     = jr[9:0];
      node.node_col     = jc[9:0];
      node.node_type    = kind;
      node.branch_count = cnt;
      expected_nodes    = {expected_nodes, node};
    end
    if (pos_row == h + 1) begin
      pos_row = 0;
      pos_col = 0;
    end else if (pos_col + 1 >= w) begin
      pos_row++;
      pos_col = 0;
    end else begin
      pos_col++;
    end
  endfunction

  function automatic void flag(string field, logic [9:0] want_v, logic [9:0] got_v);
    fails++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
  endfunction

  // everything is sampled at the falling edge ahead of the rising edge that acts on it
  always @(negedge clk) begin : watch
    snc_out_t want;
    if (!rst_n) begin
      width_reg  = CFG_RESET_WIDTH;
      height_reg = CFG_RESET_HEIGHT;
      win        = '0;
      pos_row    = 0;
      pos_col    = 0;
      for (int b = 0; b < 2; b++)
        for (int i = 0; i < SNC_MAX_WIDTH; i++) line_bank[b][i] = 1'b0;
      expected_nodes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == CFG_IDX_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_valid && !in_stall) take_request(in_data);
      if (out_valid && !out_stall) begin
        if (expected_nodes.size() == 0) begin
          fails++;
          $display("%0t: result mismatch, expected none actual row %0d col %0d type %0d count %0d",
                   $time, out_data.node_row, out_data.node_col, out_data.node_type,
                   out_data.branch_count);
        end else begin
          want = expected_nodes.pop_front();
          if (out_data.node_row !== want.node_row)
            flag("node_row", want.node_row, out_data.node_row);
          if (out_data.node_col !== want.node_col)
            flag("node_col", want.node_col, out_data.node_col);
          if (out_data.node_type !== want.node_type)
            flag("node_type", want.node_type, out_data.node_type);
          if (out_data.branch_count !== want.branch_count)
            flag("branch_count", want.branch_count, out_data.branch_count);
        end
      end
    end
    waiting = expected_nodes.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams binary skeleton frames into the node classifier under several
// sizes and idle patterns; a checker beside the block predicts every node
// and this top drives requests, writes and stalls and reports the verdict.
// ---------------------------------------------------------------------------
module testbench;
  import snc_pkg::*;

  localparam int SMALL_PHASE_REQS = 70;     // minimum requests per small-frame phase
  localparam int PHASES           = 13;
  localparam int LONG_HOLD        = 400;    // receiver hold-off, in cycles
  localparam int LIMIT_CYCLES     = 400000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  snc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  snc_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors;
  int outstanding;
  int send_idle_pct = 0;   // chance the sender skips a cycle
  int stall_pct     = 0;   // chance the receiver stalls a cycle
  int hold_asks     = 0;   // long hold-offs asked by the stimulus
  int holds_done    = 0;
  int hold_left     = 0;
  int requests_sent = 0;
  int cycles        = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  skeleton_node_classifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  snc_node_checker node_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // watchdog: covers the line-buffer clearing pass, stalls and long holds
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side. A long hold-off is counted here, independent of the
  // sender, so the pipeline fills up and in_stall has to rise.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done != hold_asks) begin
      holds_done = holds_done + 1;
      hold_left  = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int size_used(int v, int hi);
    if (v < CFG_MIN_SIZE) return CFG_MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // One request: random idle cycles first, then hold valid until taken.
  // in_stall is read at the falling edge, where it is already settled.
  task automatic send_request(logic k, logic px);
    snc_in_t req;
    bit      taken;
    req.kind  = k;
    req.pixel = px;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pauses until every predicted node is out, then lets the
  // two-stage pipeline run empty in case the last requests made no node.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // 3x3 frame, bit 3*row+col; the four trailing requests are the flush row
  task automatic send_tile(bit [8:0] pix, bit [8:0] as_flush, logic tail_kind);
    for (int i = 0; i < 9; i++)
      send_request(as_flush[i] ? KIND_FLUSH : KIND_PIXEL, pix[i]);
    repeat (4) send_request(tail_kind, 1'b1);
  endtask

  // Full frame plus its w+1 flush requests. With noise, a few flush
  // requests land inside the frame and a few pixels inside the flush row.
  task automatic send_frame(int w, int h, int dens, bit noisy);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (noisy && $urandom_range(99) < 3) send_request(KIND_FLUSH, 1'($urandom_range(1)));
        else send_request(KIND_PIXEL, $urandom_range(99) < dens);
    for (int i = 0; i <= w; i++)
      if (noisy && $urandom_range(99) < 10) send_request(KIND_PIXEL, 1'($urandom_range(1)));
      else send_request(KIND_FLUSH, 1'($urandom_range(1)));
  endtask

  // unaligned random requests, used for the huge sizes
  task automatic send_loose(int n);
    repeat (n)
      send_request(($urandom_range(99) < 8) ? KIND_FLUSH : KIND_PIXEL,
                   $urandom_range(99) < 35);
  endtask

  initial begin : stimulus
    int wv;
    int hv;
    int start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two 3x3 frames. First: a center junction of three apart
    // branches whose three tips are endpoints, closed by flush requests.
    // Second: four diagonal branches (junction), one top pixel sent as a
    // flush request, and pixel requests with value 1 in the flush row.
    write_reg(CFG_IDX_WIDTH, 11'd3);
    write_reg(CFG_IDX_HEIGHT, 11'd3);
    send_tile(9'b010_010_101, 9'b000_000_000, KIND_FLUSH);
    send_tile(9'b101_010_111, 9'b000_000_010, KIND_PIXEL);
    settle();

    for (int k = 0; k < PHASES; k++) begin
      unique case (k)
        3:       begin wv = 2047; hv = 0;    end  // clamps to 1024 x 3
        4:       begin wv = 5;    hv = 4;    end  // shrinks mid-row
        5:       begin wv = 0;    hv = 1;    end  // clamps to 3 x 3
        6:       begin wv = 3;    hv = 3;    end
        7:       begin wv = 3;    hv = 2047; end  // clamps to 3 x 1024
        8:       begin wv = 1024; hv = 1024; end
        default: begin
          wv = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
          hv = $urandom_range(3, 10);
        end
      endcase
      write_reg(CFG_IDX_WIDTH, wv[CFG_DATA_W-1:0]);
      write_reg(CFG_IDX_HEIGHT, hv[CFG_DATA_W-1:0]);

      unique case (k % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 65; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      if (k == 0 || k == 4) hold_asks++;

      if (k == 3) send_loose(200);
      else if (k == 7) send_loose(90);
      else if (k == 8) send_loose(40);
      else begin
        start = requests_sent;
        while (requests_sent - start < SMALL_PHASE_REQS)
          send_frame(size_used(wv, SNC_MAX_WIDTH), size_used(hv, SNC_MAX_HEIGHT),
                     $urandom_range(15, 55), k >= 2);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
